// ----- sv/triangle_tangent_space_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Triangle tangent space unit - assertion macros
// Shared property shorthands for the blocks of the tangent space unit.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_SPACE_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_SPACE_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset
`define TTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define TTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle tangent space package
// Formats, job and status types, back-end states and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int QUOT_BITS = DATA_W - 1;
    localparam int CNT_W     = $clog2(QUOT_BITS + 1);
    localparam int DVD_W     = PROD_W + FRAC_BITS;
    localparam int HEAD_W    = DVD_W - QUOT_BITS;
    localparam int CMP_W     = (HEAD_W > PROD_W) ? HEAD_W : PROD_W;

    localparam logic [1:0] CORNER_FIRST  = 2'd0;
    localparam logic [1:0] CORNER_SECOND = 2'd1;
    localparam logic [1:0] CORNER_THIRD  = 2'd2;

    localparam logic [2:0] TERM_DET    = 3'd0;
    localparam logic [2:0] TERM_TAN_X  = 3'd1;
    localparam logic [2:0] TERM_TAN_Y  = 3'd2;
    localparam logic [2:0] TERM_TAN_Z  = 3'd3;
    localparam logic [2:0] TERM_BIT_X  = 3'd4;
    localparam logic [2:0] TERM_BIT_Y  = 3'd5;
    localparam logic [2:0] TERM_LAST   = 3'd6;

    localparam logic [1:0] COPY_LAST   = 2'd2;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [PROD_W-1:0] t_wide;

    // Edges of one triangle, deltas already saturated
    typedef struct packed {
        logic [2:0][DATA_W-1:0] dp1;
        logic [2:0][DATA_W-1:0] dp2;
        t_word                  du1;
        t_word                  dv1;
        t_word                  du2;
        t_word                  dv2;
    } t_job;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUB,
        ST_EVAL,
        ST_DIV_WAIT,
        ST_EMIT
    } t_back_state;

    // a - b, saturated to the signed word range
    function automatic t_word sat_diff(input t_word a, input t_word b);
        logic [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1]) begin
            sat_diff = d[DATA_W] ? SAT_MIN : SAT_MAX;
        end else begin
            sat_diff = d[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/tts_front.sv -----
// ----------------------------------------------------------------------------
// Tangent space front end
// Collects corners, forms saturated edges on the third corner, issues a job.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [31:0]         i_pos_x,
    input  wire  [31:0]         i_pos_y,
    input  wire  [31:0]         i_pos_z,
    input  wire  [31:0]         i_tex_u,
    input  wire  [31:0]         i_tex_v,
    output logic                o_job_valid,
    input  wire                 i_job_ready,
    output tts_pkg::t_job       o_job
);
    import tts_pkg::*;

    logic [1:0]             r_count;
    logic [1:0]             n_count;
    logic [2:0][DATA_W-1:0] r_p0;
    logic [2:0][DATA_W-1:0] r_p1;
    logic [1:0][DATA_W-1:0] r_uv0;
    logic [1:0][DATA_W-1:0] r_uv1;
    logic [2:0][DATA_W-1:0] pos;
    logic                   is_third;
    logic                   accept;

    assign pos      = {i_pos_z, i_pos_y, i_pos_x};
    assign is_third = (r_count == CORNER_THIRD);
    assign o_ready  = !is_third || i_job_ready;
    assign accept   = i_valid && o_ready;

    // Advance the corner count
    always_comb begin
        n_count = r_count;
        if (accept) begin
            case (r_count)
                CORNER_FIRST:  n_count = CORNER_SECOND;
                CORNER_SECOND: n_count = CORNER_THIRD;
                CORNER_THIRD:  n_count = CORNER_FIRST;
                default:       n_count = CORNER_SECOND;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CORNER_FIRST;
        end else begin
            r_count <= n_count;
        end
    end

    // Hold the first two corners
    always_ff @(posedge i_clk) begin
        if (accept && r_count == CORNER_SECOND) begin
            r_p1  <= pos;
            r_uv1 <= {i_tex_v, i_tex_u};
        end else if (accept && !is_third) begin
            r_p0  <= pos;
            r_uv0 <= {i_tex_v, i_tex_u};
        end
    end

    // Form the edges of the triangle
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_job.dp1[i] = sat_diff(r_p1[i], r_p0[i]);
            o_job.dp2[i] = sat_diff(pos[i], r_p0[i]);
        end
        o_job.du1 = sat_diff(r_uv1[0], r_uv0[0]);
        o_job.dv1 = sat_diff(r_uv1[1], r_uv0[1]);
        o_job.du2 = sat_diff(i_tex_u, r_uv0[0]);
        o_job.dv2 = sat_diff(i_tex_v, r_uv0[1]);
    end

    assign o_job_valid = i_valid && is_third;

endmodule

`default_nettype wire

// ----- sv/tts_queue.sv -----
// ----------------------------------------------------------------------------
// Tangent space job queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  tts_pkg::t_job       i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tts_pkg::t_job       o_out_data
);
    import tts_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_fill;
    logic       push;
    logic       pop;

    assign o_in_ready  = (r_fill != 2'd2);
    assign o_out_valid = (r_fill != 2'd0);
    assign o_out_data  = r_mem[r_rd];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    // Store an entry on each incoming transfer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_in_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// ----- sv/tts_divider.sv -----
// ----------------------------------------------------------------------------
// Tangent space divider
// Bit-serial (num * 2^FRAC_BITS) / den, truncated, saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_divider (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire  [63:0]         i_num,
    input  wire  [63:0]         i_den,
    output tts_pkg::t_div_stat  o_stat,
    output logic [31:0]         o_quot
);
    import tts_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_ovf;
    logic                 r_neg;
    t_wide                r_rem;
    t_wide                r_den;
    logic [QUOT_BITS-1:0] r_low;
    logic [QUOT_BITS-1:0] r_q;
    logic [DATA_W-1:0]    r_quot;

    t_wide                n_mag;
    t_wide                d_mag;
    logic [DVD_W-1:0]     dividend;
    logic [CMP_W-1:0]     head_ext;
    logic [CMP_W-1:0]     den_ext;
    logic                 ovf;
    logic [PROD_W:0]      trial;
    logic [PROD_W:0]      trial_sub;
    logic                 take;

    // Split operands into magnitude and sign
    always_comb begin
        n_mag    = i_num[PROD_W-1] ? (PROD_W'(0) - i_num) : i_num;
        d_mag    = i_den[PROD_W-1] ? (PROD_W'(0) - i_den) : i_den;
        dividend = {n_mag, {FRAC_BITS{1'b0}}};
        head_ext = CMP_W'(dividend[DVD_W-1:QUOT_BITS]);
        den_ext  = CMP_W'(d_mag);
        ovf      = (head_ext >= den_ext);
    end

    // One restoring step
    always_comb begin
        trial     = {r_rem, r_low[QUOT_BITS-1]};
        trial_sub = trial - {1'b0, r_den};
        take      = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ovf ? CNT_W'(0) : CNT_W'(QUOT_BITS);
            end else if (r_busy && r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Load operands, iterate, then saturate and sign the quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= ovf;
            r_neg <= i_num[PROD_W-1] ^ i_den[PROD_W-1];
            r_rem <= head_ext[PROD_W-1:0];
            r_den <= d_mag;
            r_low <= dividend[QUOT_BITS-1:0];
            r_q   <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= take ? trial_sub[PROD_W-1:0] : trial[PROD_W-1:0];
            r_low <= {r_low[QUOT_BITS-2:0], 1'b0};
            r_q   <= {r_q[QUOT_BITS-2:0], take};
        end else if (r_busy) begin
            if (r_ovf) begin
                r_quot <= r_neg ? SAT_MIN : SAT_MAX;
            end else begin
                r_quot <= r_neg ? (DATA_W'(0) - {1'b0, r_q}) : {1'b0, r_q};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

`default_nettype wire

// ----- sv/tts_back.sv -----
// ----------------------------------------------------------------------------
// Tangent space back end
// Sequences the shared multiplier and divider over one job, emits 3 copies.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_tangent_space_unit_defines.svh"

module tts_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_job_valid,
    output logic                o_job_ready,
    input  tts_pkg::t_job       i_job,
    output logic                o_div_start,
    output logic [63:0]         o_div_num,
    output logic [63:0]         o_div_den,
    input  tts_pkg::t_div_stat  i_div_stat,
    input  wire  [31:0]         i_div_quot,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [31:0]         o_tangent_x,
    output logic [31:0]         o_tangent_y,
    output logic [31:0]         o_tangent_z,
    output logic [31:0]         o_bitangent_x,
    output logic [31:0]         o_bitangent_y,
    output logic [31:0]         o_bitangent_z,
    output logic                o_degenerate,
    output logic                o_last_copy
);
    import tts_pkg::*;

    t_back_state            r_state;
    t_back_state            n_state;
    logic [2:0]             r_term;
    t_job                   r_job;
    t_wide                  r_pa;
    t_wide                  r_pb;
    t_wide                  r_diff;
    t_wide                  r_det;
    logic                   r_degen;
    logic [2:0][DATA_W-1:0] r_tan;
    logic [2:0][DATA_W-1:0] r_bit;
    logic [1:0]             r_copy;

    t_word                  op_a;
    t_word                  op_b;
    t_word                  op_c;
    t_word                  op_d;
    t_word                  mul_x;
    t_word                  mul_y;
    t_wide                  product;
    logic                   term_done;
    t_word                  term_val;
    logic [1:0]             tan_idx;
    logic [1:0]             bit_idx;

    // Pick the operand pairs of the current term
    always_comb begin
        tan_idx = 2'(r_term - TERM_TAN_X);
        bit_idx = 2'(r_term - TERM_BIT_X);
        case (r_term)
            TERM_DET: begin
                op_a = r_job.du1;
                op_b = r_job.dv2;
                op_c = r_job.dv1;
                op_d = r_job.du2;
            end
            TERM_TAN_X, TERM_TAN_Y, TERM_TAN_Z: begin
                op_a = r_job.dp1[tan_idx];
                op_b = r_job.dv2;
                op_c = r_job.dp2[tan_idx];
                op_d = r_job.dv1;
            end
            TERM_BIT_X, TERM_BIT_Y, TERM_LAST: begin
                op_a = r_job.dp2[bit_idx];
                op_b = r_job.du1;
                op_c = r_job.dp1[bit_idx];
                op_d = r_job.du2;
            end
            default: begin
                op_a = '0;
                op_b = '0;
                op_c = '0;
                op_d = '0;
            end
        endcase
        mul_x   = (r_state == ST_MUL_A) ? op_a : op_c;
        mul_y   = (r_state == ST_MUL_A) ? op_b : op_d;
        product = $signed(mul_x) * $signed(mul_y);
    end

    // Next state and handshake outputs
    always_comb begin
        n_state     = r_state;
        o_job_ready = 1'b0;
        o_div_start = 1'b0;
        term_done   = 1'b0;
        term_val    = '0;
        case (r_state)
            ST_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_state = ST_MUL_A;
                end
            end
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_SUB;
            ST_SUB:   n_state = ST_EVAL;
            ST_EVAL: begin
                if (r_term == TERM_DET) begin
                    n_state = ST_MUL_A;
                end else if (r_degen) begin
                    term_done = 1'b1;
                end else begin
                    o_div_start = 1'b1;
                    n_state     = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (i_div_stat.done) begin
                    term_done = 1'b1;
                    term_val  = i_div_quot;
                end
            end
            ST_EMIT: begin
                if (i_ready && r_copy == COPY_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (term_done) begin
            n_state = (r_term == TERM_LAST) ? ST_EMIT : ST_MUL_A;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_term  <= TERM_DET;
            r_copy  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_term <= TERM_DET;
                r_copy <= 2'd0;
            end else if ((r_state == ST_EVAL && r_term == TERM_DET) || term_done) begin
                r_term <= r_term + 3'd1;
            end
            if (r_state == ST_EMIT && i_ready) begin
                r_copy <= r_copy + 2'd1;
            end
        end
    end

    // Datapath: take job, multiply, subtract, store terms
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_job_valid) begin
            r_job <= i_job;
        end
        if (r_state == ST_MUL_A) begin
            r_pa <= product;
        end
        if (r_state == ST_MUL_B) begin
            r_pb <= product;
        end
        if (r_state == ST_SUB) begin
            r_diff <= r_pa - r_pb;
        end
        if (r_state == ST_EVAL && r_term == TERM_DET) begin
            r_det   <= r_diff;
            r_degen <= (r_diff == '0);
        end
        if (term_done) begin
            if (r_term <= TERM_TAN_Z) begin
                r_tan[tan_idx] <= term_val;
            end else begin
                r_bit[bit_idx] <= term_val;
            end
        end
    end

    assign o_div_num     = r_diff;
    assign o_div_den     = r_det;
    assign o_valid       = (r_state == ST_EMIT);
    assign o_tangent_x   = r_tan[0];
    assign o_tangent_y   = r_tan[1];
    assign o_tangent_z   = r_tan[2];
    assign o_bitangent_x = r_bit[0];
    assign o_bitangent_y = r_bit[1];
    assign o_bitangent_z = r_bit[2];
    assign o_degenerate  = r_degen;
    assign o_last_copy   = (r_copy == COPY_LAST);

    `TTS_ASSERT_IMP(a_div_tracked, i_clk, i_rst_n, r_state == ST_DIV_WAIT, i_div_stat.busy || i_div_stat.done, "divider idle while back end waits")
    `TTS_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, r_state == ST_EMIT && r_degen, r_tan == '0 && r_bit == '0, "degenerate result carries nonzero vectors")
    `TTS_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, o_valid && i_ready && o_last_copy, r_state == ST_IDLE, "back end did not release after last copy")
    `TTS_ASSERT_IMP(a_start_free, i_clk, i_rst_n, o_div_start, !i_div_stat.busy, "divider started while busy")

endmodule

`default_nettype wire

// ----- sv/triangle_tangent_space_unit.sv -----
// Three results per triangle. The back end takes a new job only when idle, after the
// last copy of the previous one, and works it on the shared 32x32 multiplier and the
// bit-serial divider (31 quotient bits per term).
// Front end takes corners one per cycle; the third corner of a triangle waits for room in the two-entry job queue.
// Reset (synchronous, active low) clears corner count, queue and sequencer state;
// corner stores and datapath registers are not cleared.
// ----------------------------------------------------------------------------
// Triangle tangent space unit
// Per-triangle tangent and bitangent from positions and texture coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_space_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [31:0] i_pos_x,
    input  wire  [31:0] i_pos_y,
    input  wire  [31:0] i_pos_z,
    input  wire  [31:0] i_tex_u,
    input  wire  [31:0] i_tex_v,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_tangent_x,
    output logic [31:0] o_tangent_y,
    output logic [31:0] o_tangent_z,
    output logic [31:0] o_bitangent_x,
    output logic [31:0] o_bitangent_y,
    output logic [31:0] o_bitangent_z,
    output logic        o_degenerate,
    output logic        o_last_copy
);
    import tts_pkg::*;

    logic      fq_valid;
    logic      fq_ready;
    t_job      fq_job;
    logic      qb_valid;
    logic      qb_ready;
    t_job      qb_job;
    logic      div_start;
    t_wide     div_num;
    t_wide     div_den;
    t_div_stat div_stat;
    t_word     div_quot;

    tts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_tex_u     (i_tex_u),
        .i_tex_v     (i_tex_v),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (fq_job)
    );

    tts_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (fq_valid),
        .o_in_ready  (fq_ready),
        .i_in_data   (fq_job),
        .o_out_valid (qb_valid),
        .i_out_ready (qb_ready),
        .o_out_data  (qb_job)
    );

    tts_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    tts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (qb_valid),
        .o_job_ready   (qb_ready),
        .i_job         (qb_job),
        .o_div_start   (div_start),
        .o_div_num     (div_num),
        .o_div_den     (div_den),
        .i_div_stat    (div_stat),
        .i_div_quot    (div_quot),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_tangent_x   (o_tangent_x),
        .o_tangent_y   (o_tangent_y),
        .o_tangent_z   (o_tangent_z),
        .o_bitangent_x (o_bitangent_x),
        .o_bitangent_y (o_bitangent_y),
        .o_bitangent_z (o_bitangent_z),
        .o_degenerate  (o_degenerate),
        .o_last_copy   (o_last_copy)
    );

endmodule

`default_nettype wire

// ----- tb/triangle_tangent_space_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent space unit - result checker
// Watches both channels, predicts the tangent and bitangent of each
// triangle from the accepted corners and compares every result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_space_unit_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire         i_ready_in,
    input  wire  [31:0] i_pos_x,
    input  wire  [31:0] i_pos_y,
    input  wire  [31:0] i_pos_z,
    input  wire  [31:0] i_tex_u,
    input  wire  [31:0] i_tex_v,
    input  wire         i_out_valid,
    input  wire         i_ready,
    input  wire  [31:0] i_tangent_x,
    input  wire  [31:0] i_tangent_y,
    input  wire  [31:0] i_tangent_z,
    input  wire  [31:0] i_bitangent_x,
    input  wire  [31:0] i_bitangent_y,
    input  wire  [31:0] i_bitangent_z,
    input  wire         i_degenerate,
    input  wire         i_last_copy,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_degen_seen
);
    import tts_pkg::*;

    typedef struct {
        t_word tan [3];
        t_word bit_v [3];
        logic  degen;
        logic  last;
    } t_tangent_frame;

    t_tangent_frame frame_q[$];
    logic [1:0]     corner_idx;
    t_word          stored_pos [2][3];
    t_word          stored_uv  [2][2];

    // Saturating edge delta a - b
    function automatic t_word edge_delta(input t_word a, input t_word b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        if (d > 33'sd2147483647)       edge_delta = SAT_MAX;
        else if (d < -33'sd2147483648) edge_delta = SAT_MIN;
        else                           edge_delta = d[31:0];
    endfunction

    // (num << FRAC_BITS) / den, truncated toward zero, saturated
    function automatic t_word scaled_quot(input logic signed [63:0] num,
                                          input logic signed [63:0] den);
        logic signed [127:0] n;
        logic signed [127:0] d;
        logic signed [127:0] q;
        n = num;
        d = den;
        n = n <<< FRAC_BITS;
        q = n / d;
        if (q > 128'sd2147483647)       scaled_quot = SAT_MAX;
        else if (q < -128'sd2147483648) scaled_quot = SAT_MIN;
        else                            scaled_quot = q[31:0];
    endfunction

    // Wrapping 64-bit product of two signed words
    function automatic logic signed [63:0] wide_mul(input t_word a, input t_word b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        sa = $signed(a);
        sb = $signed(b);
        wide_mul = sa * sb;
    endfunction

    task automatic predict_frame(input t_word p2 [3], input t_word uv2 [2]);
        t_word              dp1 [3];
        t_word              dp2 [3];
        t_word              du1, dv1, du2, dv2;
        logic signed [63:0] det;
        t_tangent_frame     f;
        for (int i = 0; i < 3; i++) begin
            dp1[i] = edge_delta(stored_pos[1][i], stored_pos[0][i]);
            dp2[i] = edge_delta(p2[i], stored_pos[0][i]);
        end
        du1 = edge_delta(stored_uv[1][0], stored_uv[0][0]);
        dv1 = edge_delta(stored_uv[1][1], stored_uv[0][1]);
        du2 = edge_delta(uv2[0], stored_uv[0][0]);
        dv2 = edge_delta(uv2[1], stored_uv[0][1]);
        det = wide_mul(du1, dv2) - wide_mul(dv1, du2);
        f.degen = (det == 0);
        for (int i = 0; i < 3; i++) begin
            if (f.degen) begin
                f.tan[i]   = '0;
                f.bit_v[i] = '0;
            end else begin
                f.tan[i]   = scaled_quot(wide_mul(dp1[i], dv2) - wide_mul(dp2[i], dv1), det);
                f.bit_v[i] = scaled_quot(wide_mul(dp2[i], du1) - wide_mul(dp1[i], du2), det);
            end
        end
        for (int k = 0; k < 3; k++) begin
            f.last = (k == 2);
            frame_q.insert(frame_q.size(), f);
        end
    endtask

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        o_fail_count++;
        $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_degen_seen = 0;
        o_pending    = 0;
        corner_idx   = CORNER_FIRST;
    end

    always @(posedge i_clk) begin
        t_tangent_frame want;
        t_word          p [3];
        t_word          uv [2];
        if (!i_rst_n) begin
            corner_idx <= CORNER_FIRST;
            frame_q.delete();
        end else begin
            // Compare one result transfer against the oldest prediction
            if (i_out_valid && i_ready) begin
                if (frame_q.size() == 0) begin
                    o_fail_count++;
                    $display("[%0t] unexpected result transfer", $time);
                end else begin
                    want = frame_q.pop_front();
                    o_checked++;
                    if (want.degen) o_degen_seen++;
                    if (i_tangent_x   !== want.tan[0])   report_mismatch("tangent_x",   i_tangent_x,   want.tan[0]);
                    if (i_tangent_y   !== want.tan[1])   report_mismatch("tangent_y",   i_tangent_y,   want.tan[1]);
                    if (i_tangent_z   !== want.tan[2])   report_mismatch("tangent_z",   i_tangent_z,   want.tan[2]);
                    if (i_bitangent_x !== want.bit_v[0]) report_mismatch("bitangent_x", i_bitangent_x, want.bit_v[0]);
                    if (i_bitangent_y !== want.bit_v[1]) report_mismatch("bitangent_y", i_bitangent_y, want.bit_v[1]);
                    if (i_bitangent_z !== want.bit_v[2]) report_mismatch("bitangent_z", i_bitangent_z, want.bit_v[2]);
                    if (i_degenerate  !== want.degen)    report_mismatch("degenerate",  i_degenerate,  want.degen);
                    if (i_last_copy   !== want.last)     report_mismatch("last_copy",   i_last_copy,   want.last);
                end
            end
            // Store the first two corners, predict on the third
            if (i_valid && i_ready_in) begin
                p[0] = i_pos_x; p[1] = i_pos_y; p[2] = i_pos_z;
                uv[0] = i_tex_u; uv[1] = i_tex_v;
                if (corner_idx == CORNER_THIRD) begin
                    predict_frame(p, uv);
                    corner_idx <= CORNER_FIRST;
                end else begin
                    stored_pos[corner_idx] = p;
                    stored_uv[corner_idx]  = uv;
                    corner_idx <= corner_idx + 2'd1;
                end
            end
        end
        // Publish the number of outstanding results
        o_pending = frame_q.size();
    end

endmodule

`default_nettype wire

// ----- tb/triangle_tangent_space_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent space unit - testbench top
// Streams directed and random triangles with random gaps and back pressure;
// the checker predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_space_unit_tb;
    import tts_pkg::*;

    localparam int    CYCLE_LIMIT = 600000;
    localparam int    RAND_TRIS   = 67;
    localparam t_word ONE         = 32'h0001_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_tangent_x, o_tangent_y, o_tangent_z;
    logic [31:0] o_bitangent_x, o_bitangent_y, o_bitangent_z;
    logic        o_degenerate;
    logic        o_last_copy;

    int          fail_count, pending, checked, degen_seen;
    int          cycle_cnt;
    int          tri_cnt;
    logic        steady;

    triangle_tangent_space_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_tex_u       (i_tex_u),
        .i_tex_v       (i_tex_v),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_tangent_x   (o_tangent_x),
        .o_tangent_y   (o_tangent_y),
        .o_tangent_z   (o_tangent_z),
        .o_bitangent_x (o_bitangent_x),
        .o_bitangent_y (o_bitangent_y),
        .o_bitangent_z (o_bitangent_z),
        .o_degenerate  (o_degenerate),
        .o_last_copy   (o_last_copy)
    );

    triangle_tangent_space_unit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ready_in    (o_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_tex_u       (i_tex_u),
        .i_tex_v       (i_tex_v),
        .i_out_valid   (o_valid),
        .i_ready       (i_ready),
        .i_tangent_x   (o_tangent_x),
        .i_tangent_y   (o_tangent_y),
        .i_tangent_z   (o_tangent_z),
        .i_bitangent_x (o_bitangent_x),
        .i_bitangent_y (o_bitangent_y),
        .i_bitangent_z (o_bitangent_z),
        .i_degenerate  (o_degenerate),
        .i_last_copy   (o_last_copy),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_degen_seen  (degen_seen)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side stalls about 30 percent of cycles outside the steady stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else          i_ready <= steady || ($urandom_range(99) >= 30);
    end

    // Drive one vertex and hold it until its transfer
    task automatic send_vertex(input t_word px, input t_word py, input t_word pz,
                               input t_word u, input t_word v);
        while (!steady && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        i_tex_u <= u;
        i_tex_v <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Random coordinate: mostly small, sometimes full range
    function automatic t_word rand_coord(input bit wide);
        if (wide) rand_coord = $urandom;
        else      rand_coord = $urandom_range(8 * ONE) - 4 * ONE;
    endfunction

    task automatic send_random_tri();
        bit    wide;
        bit    flat;
        t_word u0, v0;
        wide = ($urandom_range(99) < 30);
        flat = ($urandom_range(99) < 12);
        u0 = rand_coord(wide);
        v0 = rand_coord(wide);
        send_vertex(rand_coord(wide), rand_coord(wide), rand_coord(wide), u0, v0);
        for (int k = 0; k < 2; k++) begin
            if (flat) send_vertex(rand_coord(wide), rand_coord(wide), rand_coord(wide), u0, v0);
            else      send_vertex(rand_coord(wide), rand_coord(wide), rand_coord(wide),
                                  rand_coord(wide), rand_coord(wide));
        end
        tri_cnt++;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_tex_u = '0; i_tex_v = '0;
        steady  = 1'b0;
        tri_cnt = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unit right triangle, identity mapping
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(ONE, 0, 0, ONE, 0);
        send_vertex(0, ONE, 0, 0, ONE);
        // Coincident UVs: degenerate
        send_vertex(ONE, 2 * ONE, 3 * ONE, ONE, ONE);
        send_vertex(5 * ONE, 0, -ONE, ONE, ONE);
        send_vertex(-ONE, ONE, 7, ONE, ONE);
        // Collinear UVs: degenerate
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(ONE, ONE, 0, ONE, 2 * ONE);
        send_vertex(3 * ONE, 0, ONE, 2 * ONE, 4 * ONE);
        // Tiny determinant, large edges: quotient saturates both ways
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(SAT_MAX, SAT_MIN, 32'h4000_0000, 1, 0);
        send_vertex(SAT_MIN, SAT_MAX, 32'hC000_0000, 0, 1);
        // Extremes: edge deltas saturate
        send_vertex(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX);
        send_vertex(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN);
        send_vertex(SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN);
        // All-ones and all-max corners
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_vertex(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 32'hFFFF_FFFF);
        send_vertex(SAT_MAX, SAT_MAX, SAT_MAX, 32'hFFFF_FFFF, SAT_MAX);
        // Mirrored UVs: negative determinant
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(ONE, 0, ONE, 0, ONE);
        send_vertex(0, ONE, -ONE, ONE, 0);
        tri_cnt = 7;

        // Hold off until every expected result has arrived
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        for (int t = 0; t < RAND_TRIS; t++) begin
            steady = (t >= 25 && t < 40);
            send_random_tri();
        end
        i_valid <= 1'b0;
        steady = 1'b0;

        // Drain, then allow the pipeline to settle
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("covered %0d triangles, %0d results checked (%0d degenerate)",
                 tri_cnt, checked, degen_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- triangle_tangent_space_unit.f -----
+incdir+sv
sv/tts_pkg.sv
sv/tts_front.sv
sv/tts_queue.sv
sv/tts_divider.sv
sv/tts_back.sv
sv/triangle_tangent_space_unit.sv
tb/triangle_tangent_space_unit_checker.sv
tb/triangle_tangent_space_unit_tb.sv
